// File: rtl/cmas_pkg.sv
// ----------------------------------------------------------------------------
// cmas_pkg
// Shared types and constants of the centered moving average smoother.
// ----------------------------------------------------------------------------
package cmas_pkg;

  localparam int SPAN_W  = 6;
  localparam int LEN_W   = 16;
  localparam int POS_W   = LEN_W + 2;   // signed position math, holds len - 1 - c
  localparam int CFG_W   = LEN_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(5);
  localparam logic [LEN_W-1:0]  LEN_RST  = LEN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPAN          = 1'b0,
    REG_COLUMN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_JOB  = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } cmas_state_t;

endpackage

// File: rtl/centered_moving_average_smoother_unit.sv
// ----------------------------------------------------------------------------
// centered_moving_average_smoother_unit
// Centered moving average over a column of samples, window shrinking
// symmetrically at both column ends, rounded mean via a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample per item (valid/ready). in_ready is high only while
//           the unit is idle; each item is fully processed before the next.
//   out_* : smoothed sample, end_of_column mark and bad_span flag
//           (valid/ready). Results sit in an output register, so a stalled
//           receiver holds only the final emit step of the next result.
//   cfg_* : write port, index 0 = span, index 1 = column_length; write only
//           while idle.
// Flow: each mean of radius r first sets up the window, then reads and
//   sums its 2r+1 samples from the sample memory (one read port), then
//   runs the bit-serial divider and finally emits. A column end produces
//   up to half+1 results back to back from one item. A bad span result
//   skips the sum and the divider and goes straight to the emit step.
// Reset: span = 5, column_length = 256, position 0, output empty. The
//   sample memory is not cleared; only entries of the current column are
//   ever read.
// ----------------------------------------------------------------------------
module centered_moving_average_smoother_unit #(
  parameter int MAX_HALF_WIDTH = 15,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_smoothed,
  output logic                                out_end_of_column,
  output logic                                out_bad_span,
  input  logic                                cfg_wr_en,
  input  logic [cmas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmas_pkg::CFG_W-1:0]          cfg_wdata
);
  import cmas_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HALF_WIDTH + 1);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int SW    = SAMPLE_BITS + AW;          // window sum width
  localparam int DW    = SW;                        // dividend width
  localparam int CW    = $clog2(DW + 1);
  localparam int HW    = 7;                         // holds span-derived half width
  localparam logic [HW-1:0] MHW_H = HW'(MAX_HALF_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // configuration
  logic [SPAN_W-1:0] span_r;
  logic [LEN_W-1:0]  len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RST;
      len_r  <= LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPAN:          span_r <= cfg_wdata[SPAN_W-1:0];
        REG_COLUMN_LENGTH: len_r  <= cfg_wdata[LEN_W-1:0];
        default:           ;
      endcase
    end
  end

  // derived configuration
  logic [LEN_W:0]  len_ext;
  logic [HW-1:0]   h_raw;
  logic [RW-1:0]   half;
  logic            span_bad;

  assign len_ext  = (len_r == '0) ? {1'b1, {LEN_W{1'b0}}} : {1'b0, len_r};
  assign h_raw    = (span_r == '0) ? '0 : HW'((span_r - SPAN_W'(1)) >> 1);
  assign half     = (h_raw > MHW_H) ? RW'(MAX_HALF_WIDTH) : RW'(h_raw);
  assign span_bad = {{(LEN_W + 1 - SPAN_W){1'b0}}, span_r} > len_ext;

  // state
  cmas_state_t state_r, state_nxt;
  logic [LEN_W-1:0]  pos_r;          // index of next sample in column
  logic [LEN_W-1:0]  job_pos_r;      // position of the item being worked
  logic              job_last_r;
  logic [AW-1:0]     wp_r;           // next write address
  logic [AW-1:0]     newest_r;       // address of the newest sample
  logic [RW-1:0]     d_r;            // distance of the centered sample
  logic [NW-1:0]     n_r;            // window size 2r+1
  logic [NW-1:0]     left_r;         // reads still to issue
  logic [AW-1:0]     addr_r;
  logic              take_r;         // read data valid this cycle
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SW-1:0] sum_r;
  logic [DW-1:0]     quo_r;
  logic [NW-1:0]     rem_r;
  logic              neg_r;
  logic [CW-1:0]     div_cnt_r;
  logic              job_bad_r;
  logic              out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_smoothed_r;
  logic              out_eoc_r;
  logic              out_bad_r;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  // accept-time decisions
  logic             accept;
  logic             last;
  logic             reach_half;

  assign accept     = in_valid && in_ready;
  assign last       = ({1'b0, pos_r} + (LEN_W + 1)'(1)) >= len_ext;
  assign reach_half = pos_r >= LEN_W'(half);

  // window radius: min(h, c, len-1-c, d), floored at 0
  logic signed [POS_W-1:0] c_s, e_s, r_s, m1_s, m2_s;
  logic [RW-1:0]           radius;
  logic [AW:0]             base_s;
  logic [AW-1:0]           base_addr;

  always_comb begin
    c_s  = POS_W'($signed({2'b00, job_pos_r})) - POS_W'($signed({1'b0, d_r}));
    e_s  = POS_W'($signed({1'b0, len_ext})) - POS_W'(1) - c_s;
    m1_s = (c_s < POS_W'($signed({1'b0, half}))) ? c_s : POS_W'($signed({1'b0, half}));
    m2_s = (e_s < m1_s) ? e_s : m1_s;
    r_s  = (POS_W'($signed({1'b0, d_r})) < m2_s) ? POS_W'($signed({1'b0, d_r})) : m2_s;
    radius = (r_s < 0) ? '0 : RW'(r_s);
    // oldest entry of the window: newest - (d + r), modulo DEPTH
    base_s = {1'b0, newest_r} - ((AW + 1)'(d_r) + (AW + 1)'(radius));
    base_addr = base_s[AW] ? AW'(base_s + (AW + 1)'(DEPTH)) : base_s[AW-1:0];
  end

  // divider step
  logic [NW:0]   rem_sh;
  logic          q_bit;
  logic [SW-1:0] sum_mag;
  logic [DW-1:0] quo_signed;

  assign rem_sh     = {rem_r, quo_r[DW-1]};
  assign q_bit      = rem_sh >= {1'b0, n_r};
  assign sum_mag    = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign quo_signed = neg_r ? DW'(0) - quo_r : quo_r;

  logic out_free;
  logic more_jobs;
  assign out_free  = !out_valid_r || out_ready;
  assign more_jobs = job_last_r && !job_bad_r && (d_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (span_bad)                state_nxt = S_EMIT;
          else if (reach_half || last) state_nxt = S_JOB;
        end
      end
      S_JOB:  state_nxt = S_SUM;
      S_SUM:  if (left_r == '0 && !take_r) state_nxt = S_DIV;
      S_DIV:  if (div_cnt_r == CW'(DW - 1)) state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = more_jobs ? S_JOB : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      wp_r        <= '0;
      take_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      take_r  <= (state_r == S_SUM) && (left_r != '0);
      if (accept) begin
        pos_r <= last ? '0 : pos_r + LEN_W'(1);
        wp_r  <= (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
      end
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept) mem[wp_r] <= in_sample;
    rd_data_r <= mem[addr_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          newest_r   <= wp_r;
          job_pos_r  <= pos_r;
          job_last_r <= last;
          job_bad_r  <= span_bad;
          d_r        <= reach_half ? half : RW'(pos_r);
        end
      end
      S_JOB: begin
        n_r    <= NW'({radius, 1'b1});
        left_r <= NW'({radius, 1'b1});
        addr_r <= base_addr;
        sum_r  <= '0;
      end
      S_SUM: begin
        if (left_r != '0) begin
          left_r <= left_r - NW'(1);
          addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
        end
        if (take_r) sum_r <= sum_r + SW'(rd_data_r);
        // round half away from zero: (|s| + n/2) / n
        quo_r     <= DW'(sum_mag) + DW'(n_r >> 1);
        neg_r     <= sum_r[SW-1];
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      S_DIV: begin
        quo_r     <= {quo_r[DW-2:0], q_bit};
        rem_r     <= q_bit ? NW'(rem_sh - {1'b0, n_r}) : NW'(rem_sh);
        div_cnt_r <= div_cnt_r + CW'(1);
      end
      S_EMIT: begin
        if (out_free) begin
          out_smoothed_r <= job_bad_r ? '0 : quo_signed[SAMPLE_BITS-1:0];
          out_eoc_r      <= job_last_r && (job_bad_r || d_r == '0);
          out_bad_r      <= job_bad_r;
          if (more_jobs) d_r <= d_r - RW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_smoothed      = out_smoothed_r;
  assign out_end_of_column = out_eoc_r;
  assign out_bad_span      = out_bad_r;

endmodule
